### rtl/cre_pkg.sv
// ----------------------------------------------------------------------------
// cre_pkg: shared types and constants of the coverage run-length encoder
// Field widths, item kind and line status codes, the shared unit's operation
// codes and the result word that travels from the sequencer to the output
// register.
// ----------------------------------------------------------------------------
package cre_pkg;

  // Field widths
  localparam int KIND_W   = 2;
  localparam int COV_W    = 9;
  localparam int LEN_W    = 6;
  localparam int BYTE_W   = 8;
  localparam int STAT_W   = 2;
  localparam int LBYTES_W = 12;

  // Defaults of the top-level parameters
  localparam int LINE_WIDTH_DEF     = 1024;
  localparam int MAX_RUN_LENGTH_DEF = 32;

  // Most pixels that one zero/count pair may describe
  localparam int PAIR_MAX = 128;

  // Saturation point of the per-line byte count
  localparam logic [LBYTES_W-1:0] BYTE_COUNT_MAX = '1;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_BEGIN  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RUN    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

  // Line status codes
  localparam logic [STAT_W-1:0] STAT_ENCODED = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

  // Operations of the shared arithmetic unit
  typedef enum logic [1:0] {
    ALU_ADD,      // a + b, flag when above one pair
    ALU_ADD_SAT,  // a + b clamped at the line width, flag when clamped
    ALU_GAP       // line width - a clamped at one pair, flag when it fits
  } alu_op_t;

  // One result word
  typedef struct packed {
    logic [BYTE_W-1:0]   code_byte;
    logic                byte_valid;
    logic [STAT_W-1:0]   line_status;
    logic [LBYTES_W-1:0] line_bytes;
    logic                is_last;
  } cre_out_t;

endpackage

### rtl/cre_if.sv
// ----------------------------------------------------------------------------
// cre_if: valid/ready channels of the coverage run-length encoder
// cre_item_if carries input items, cre_result_if carries encoded bytes.
// ----------------------------------------------------------------------------
interface cre_item_if;
  logic                        valid;
  logic                        ready;
  logic [cre_pkg::KIND_W-1:0]  kind;
  logic [cre_pkg::COV_W-1:0]   coverage;
  logic [cre_pkg::LEN_W-1:0]   run_length;

  modport source (output valid, output kind, output coverage, output run_length,
                  input ready);
  modport sink   (input valid, input kind, input coverage, input run_length,
                  output ready);
endinterface

interface cre_result_if;
  logic                         valid;
  logic                         ready;
  logic [cre_pkg::BYTE_W-1:0]   code_byte;
  logic                         byte_valid;
  logic [cre_pkg::STAT_W-1:0]   line_status;
  logic [cre_pkg::LBYTES_W-1:0] line_bytes;
  logic                         is_last;

  modport source (output valid, output code_byte, output byte_valid,
                  output line_status, output line_bytes, output is_last,
                  input ready);
  modport sink   (input valid, input code_byte, input byte_valid,
                  input line_status, input line_bytes, input is_last,
                  output ready);
endinterface

### rtl/cre_alu.sv
// ----------------------------------------------------------------------------
// cre_alu: shared add / gap unit of the encoder
// One adder and one subtractor with compare, used by the sequencer for run
// merging, position advance and padding sizes.
// ----------------------------------------------------------------------------
module cre_alu #(
  parameter int W     = 11,
  parameter int LIMIT = cre_pkg::LINE_WIDTH_DEF
) (
  input  cre_pkg::alu_op_t op,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [W-1:0]     res,
  output logic             flag
);

  localparam logic [W:0] LIM  = (W+1)'(LIMIT);
  localparam logic [W:0] PAIR = (W+1)'(cre_pkg::PAIR_MAX);

  logic [W:0] sum;
  logic [W:0] gap;

  assign sum = {1'b0, a} + {1'b0, b};
  assign gap = LIM - {1'b0, a};

  // Select the operation
  always_comb begin
    unique case (op)
      cre_pkg::ALU_ADD: begin
        res  = sum[W-1:0];
        flag = (sum > PAIR);
      end
      cre_pkg::ALU_ADD_SAT: begin
        flag = (sum >= LIM);
        res  = flag ? LIM[W-1:0] : sum[W-1:0];
      end
      cre_pkg::ALU_GAP: begin
        flag = (gap <= PAIR);
        res  = flag ? gap[W-1:0] : PAIR[W-1:0];
      end
      default: begin
        res  = sum[W-1:0];
        flag = 1'b0;
      end
    endcase
  end

endmodule

### rtl/cre_obuf.sv
// ----------------------------------------------------------------------------
// cre_obuf: output register of the encoder
// Holds one result word so that the sequencer may run on while the
// downstream side stalls.
// ----------------------------------------------------------------------------
module cre_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cre_pkg::cre_out_t word,
  output logic              push_ready,
  cre_result_if.source      result
);

  logic              full;
  cre_pkg::cre_out_t data;

  assign push_ready = !full || result.ready;

  // Load a word or drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push && push_ready) begin
      full <= 1'b1;
      data <= word;
    end else if (result.ready) begin
      full <= 1'b0;
    end
  end

  assign result.valid       = full;
  assign result.code_byte   = data.code_byte;
  assign result.byte_valid  = data.byte_valid;
  assign result.line_status = data.line_status;
  assign result.line_bytes  = data.line_bytes;
  assign result.is_last     = data.is_last;

endmodule

### rtl/cre_core.sv
// ----------------------------------------------------------------------------
// cre_core: sequencer and line state of the encoder
// Takes one item at a time, drives the shared unit and emits at most one byte a
// cycle towards the output register, holding while that register stalls.
// ----------------------------------------------------------------------------
module cre_core #(
  parameter int LINE_WIDTH     = cre_pkg::LINE_WIDTH_DEF,
  parameter int MAX_RUN_LENGTH = cre_pkg::MAX_RUN_LENGTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  cre_item_if.sink          item,
  output logic              emit_valid,
  output cre_pkg::cre_out_t emit_word,
  input  logic              emit_ready
);

  localparam int POS_W = $clog2(LINE_WIDTH + 1);
  localparam int ALU_W = (POS_W > cre_pkg::COV_W) ? POS_W : cre_pkg::COV_W;
  localparam int LEN_W = cre_pkg::LEN_W;
  localparam int BW    = cre_pkg::BYTE_W;

  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_RUN_LENGTH);
  localparam logic [BW-1:0]    PAIR      = BW'(cre_pkg::PAIR_MAX);
  localparam logic [BW-1:0]    FULL_BIAS = BW'(cre_pkg::PAIR_MAX - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MERGE, S_FLUSH0, S_FLUSH1, S_LIT, S_ADV,
    S_PADCALC, S_PAD0, S_PAD1, S_MARK
  } state_t;

  typedef enum logic [1:0] {
    CLS_EMPTY, CLS_LIT, CLS_FULL
  } cls_t;

  state_t state;

  // Line state
  logic                          open_valid;
  logic                          open_full;
  logic [BW-1:0]                 open_count;
  logic [POS_W-1:0]              pos;
  logic                          pos_end;
  logic                          line_empty;
  logic                          line_full;
  logic [cre_pkg::LBYTES_W-1:0]  bc;

  // Item being worked on
  logic [cre_pkg::KIND_W-1:0]    kind_r;
  cls_t                          cls_r;
  logic [BW-1:0]                 val_r;
  logic [LEN_W-1:0]              len_r;
  logic [LEN_W-1:0]              cnt_r;
  logic [BW-1:0]                 pend_r;
  logic [BW-1:0]                 pad_n;
  logic                          pad_last;
  logic [cre_pkg::STAT_W-1:0]    status_r;

  logic                          fire_in;
  logic                          fire_out;
  logic [LEN_W-1:0]              len_c;
  cls_t                          cls_c;
  logic                          is_full;
  logic                          mergeable;
  logic                          last_flush;
  logic [BW-1:0]                 pair_byte;
  logic [cre_pkg::LBYTES_W-1:0]  bc_inc;
  logic [cre_pkg::STAT_W-1:0]    line_stat;

  cre_pkg::alu_op_t              alu_op;
  logic [ALU_W-1:0]              alu_a;
  logic [ALU_W-1:0]              alu_b;
  logic [ALU_W-1:0]              alu_res;
  logic                          alu_flag;

  cre_alu #(
    .W     (ALU_W),
    .LIMIT (LINE_WIDTH)
  ) u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .res  (alu_res),
    .flag (alu_flag)
  );

  assign item.ready = (state == S_IDLE);
  assign fire_in    = item.valid && item.ready;
  assign fire_out   = emit_valid && emit_ready;

  // Clamp the run length and classify the coverage
  assign len_c = (item.run_length > LEN_MAX) ? LEN_MAX : item.run_length;
  always_comb begin
    priority if (item.coverage[cre_pkg::COV_W-1]) begin
      cls_c = CLS_FULL;
    end else if (item.coverage == '0) begin
      cls_c = CLS_EMPTY;
    end else begin
      cls_c = CLS_LIT;
    end
  end

  assign is_full    = (cls_r == CLS_FULL);
  assign mergeable  = open_valid && (open_full == is_full) && (open_count != PAIR);
  assign last_flush = (kind_r == cre_pkg::KIND_FINISH) && pos_end;
  assign pair_byte  = open_full ? BW'(open_count + FULL_BIAS) : BW'(open_count - 1'b1);
  assign bc_inc     = (bc == cre_pkg::BYTE_COUNT_MAX) ? bc : bc + 1'b1;
  assign line_stat  = line_full ? cre_pkg::STAT_FULL : cre_pkg::STAT_ENCODED;

  // Steer the shared unit
  always_comb begin
    unique case (state)
      S_MERGE: begin
        alu_op = cre_pkg::ALU_ADD;
        alu_a  = ALU_W'(open_count);
        alu_b  = ALU_W'(len_r);
      end
      S_PADCALC: begin
        alu_op = cre_pkg::ALU_GAP;
        alu_a  = ALU_W'(pos);
        alu_b  = '0;
      end
      S_PAD1: begin
        alu_op = cre_pkg::ALU_ADD_SAT;
        alu_a  = ALU_W'(pos);
        alu_b  = ALU_W'(pad_n);
      end
      default: begin
        alu_op = cre_pkg::ALU_ADD_SAT;
        alu_a  = ALU_W'(pos);
        alu_b  = ALU_W'(len_r);
      end
    endcase
  end

  // Form the outgoing word
  always_comb begin
    emit_valid = 1'b0;
    emit_word  = '0;
    unique case (state)
      S_FLUSH0, S_PAD0: begin
        emit_valid           = 1'b1;
        emit_word.byte_valid = 1'b1;
      end
      S_FLUSH1: begin
        emit_valid           = 1'b1;
        emit_word.code_byte  = pair_byte;
        emit_word.byte_valid = 1'b1;
        if (last_flush) begin
          emit_word.is_last     = 1'b1;
          emit_word.line_status = line_stat;
          emit_word.line_bytes  = bc_inc;
        end
      end
      S_LIT: begin
        emit_valid           = 1'b1;
        emit_word.code_byte  = val_r;
        emit_word.byte_valid = 1'b1;
      end
      S_PAD1: begin
        emit_valid           = 1'b1;
        emit_word.code_byte  = BW'(pad_n - 1'b1);
        emit_word.byte_valid = 1'b1;
        if (pad_last) begin
          emit_word.is_last     = 1'b1;
          emit_word.line_status = cre_pkg::STAT_ENCODED;
          emit_word.line_bytes  = bc_inc;
        end
      end
      S_MARK: begin
        emit_valid            = 1'b1;
        emit_word.is_last     = 1'b1;
        emit_word.line_status = status_r;
        emit_word.line_bytes  = bc;
      end
      default: begin
        emit_valid = 1'b0;
      end
    endcase
  end

  // Sequencer and line state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      open_valid <= 1'b0;
      open_full  <= 1'b0;
      open_count <= '0;
      pos        <= '0;
      pos_end    <= 1'b0;
      line_empty <= 1'b1;
      line_full  <= 1'b1;
      bc         <= '0;
    end else begin
      // Count every byte handed on
      if (fire_out && emit_word.byte_valid) begin
        bc <= bc_inc;
      end

      unique case (state)
        S_IDLE: begin
          if (fire_in) begin
            kind_r <= item.kind;
            cls_r  <= cls_c;
            val_r  <= item.coverage[BW-1:0];
            len_r  <= len_c;
            cnt_r  <= len_c;
            unique case (item.kind)
              cre_pkg::KIND_BEGIN: begin
                // Clear the line and open the leading empty pair
                open_valid <= (len_c != '0);
                open_full  <= 1'b0;
                open_count <= BW'(len_c);
                pos        <= '0;
                pos_end    <= 1'b0;
                line_empty <= 1'b1;
                line_full  <= (len_c == '0);
                bc         <= '0;
                state      <= (len_c != '0) ? S_ADV : S_IDLE;
              end
              cre_pkg::KIND_RUN: begin
                if (len_c != '0) begin
                  if (cls_c != CLS_EMPTY) line_empty <= 1'b0;
                  if (cls_c != CLS_FULL)  line_full  <= 1'b0;
                  if (cls_c == CLS_LIT) begin
                    state <= open_valid ? S_FLUSH0 : S_LIT;
                  end else begin
                    state <= S_MERGE;
                  end
                end
              end
              cre_pkg::KIND_FINISH: begin
                priority if (line_empty) begin
                  status_r <= cre_pkg::STAT_EMPTY;
                  state    <= S_MARK;
                end else if (open_valid) begin
                  state <= S_FLUSH0;
                end else if (pos_end) begin
                  status_r <= line_stat;
                  state    <= S_MARK;
                end else begin
                  state <= S_PADCALC;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        S_MERGE: begin
          priority if (mergeable && !alu_flag) begin
            // Whole run fits in the open pair
            open_count <= alu_res[BW-1:0];
            state      <= S_ADV;
          end else if (mergeable) begin
            // Fill the open pair, carry the rest into a new one
            open_count <= PAIR;
            pend_r     <= BW'(alu_res - ALU_W'(cre_pkg::PAIR_MAX));
            state      <= S_FLUSH0;
          end else if (open_valid) begin
            pend_r <= BW'(len_r);
            state  <= S_FLUSH0;
          end else begin
            open_valid <= 1'b1;
            open_full  <= is_full;
            open_count <= BW'(len_r);
            state      <= S_ADV;
          end
        end

        S_FLUSH0: begin
          if (fire_out) state <= S_FLUSH1;
        end

        S_FLUSH1: begin
          if (fire_out) begin
            open_valid <= 1'b0;
            open_count <= '0;
            if (kind_r == cre_pkg::KIND_FINISH) begin
              state <= pos_end ? S_IDLE : S_PADCALC;
            end else if (cls_r == CLS_LIT) begin
              state <= S_LIT;
            end else begin
              open_valid <= 1'b1;
              open_full  <= is_full;
              open_count <= pend_r;
              state      <= S_ADV;
            end
          end
        end

        S_LIT: begin
          if (fire_out) begin
            cnt_r <= cnt_r - 1'b1;
            if (cnt_r == LEN_W'(1)) state <= S_ADV;
          end
        end

        S_ADV: begin
          pos     <= alu_res[POS_W-1:0];
          pos_end <= alu_flag;
          state   <= S_IDLE;
        end

        S_PADCALC: begin
          pad_n    <= alu_res[BW-1:0];
          pad_last <= alu_flag;
          state    <= S_PAD0;
        end

        S_PAD0: begin
          if (fire_out) state <= S_PAD1;
        end

        S_PAD1: begin
          if (fire_out) begin
            line_full <= 1'b0;
            pos       <= alu_res[POS_W-1:0];
            pos_end   <= alu_flag;
            state     <= pad_last ? S_IDLE : S_PADCALC;
          end
        end

        S_MARK: begin
          if (fire_out) state <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/coverage_run_length_encoder.sv
// ----------------------------------------------------------------------------
// coverage_run_length_encoder: scanline coverage to byte-code encoder
// Turns runs of coverage into literal bytes and zero/count pairs, merges
// neighbouring empty or full runs and pads the line on finish.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake      word
//   item     in   valid/ready    kind, coverage, run_length
//   result   out  valid/ready    code_byte, byte_valid, line_status,
//                                line_bytes, is_last
//
// One item at a time; item.ready is high only while the sequencer idles.
// Begin clears the line and opens a leading empty pair when its run is not
// empty. A coverage run of zero length is dropped; an empty or full run is
// merged into the open pair or closes it, and a literal run goes out byte by
// byte after any open pair is closed. Finish closes the open pair, then pads
// the line with zero/count pairs that the shared unit sizes, or ends on a bare
// marker. A stalled result holds the sequencer.
// Synchronous reset clears the line state at once.
// ----------------------------------------------------------------------------
module coverage_run_length_encoder #(
  parameter int LINE_WIDTH     = cre_pkg::LINE_WIDTH_DEF,
  parameter int MAX_RUN_LENGTH = cre_pkg::MAX_RUN_LENGTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  cre_item_if.sink     item,
  cre_result_if.source result
);

  logic              emit_valid;
  logic              emit_ready;
  cre_pkg::cre_out_t emit_word;

  cre_core #(
    .LINE_WIDTH     (LINE_WIDTH),
    .MAX_RUN_LENGTH (MAX_RUN_LENGTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .emit_valid (emit_valid),
    .emit_word  (emit_word),
    .emit_ready (emit_ready)
  );

  cre_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .push       (emit_valid),
    .word       (emit_word),
    .push_ready (emit_ready),
    .result     (result)
  );

  // Line summary appears on the last word of a finish only
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.is_last |->
      result.line_status == cre_pkg::STAT_ENCODED && result.line_bytes == '0)
    else $error("line summary on a word that is not last");

  // A bare marker always closes a finish
  a_bare_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.byte_valid |-> result.is_last)
    else $error("bare marker without is_last");

  // The sequencer is still busy in the cycle after it takes a finish
  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready && item.kind == cre_pkg::KIND_FINISH |=> !item.ready)
    else $error("item accepted straight after a finish");

endmodule
